### hw/rtl/wrsf_pkg.sv
// Shared types and constants of the windowed RMS and standard deviation block.
package wrsf_pkg;

   localparam int SAMPLE_W = 16;
   localparam int OUT_W = 20;
   localparam int AXES = 3;
   localparam int AXIS_W = 2;
   localparam int ROOT_W = 20;
   localparam int ROOT_ARG_W = 2 * ROOT_W;
   localparam int WINDOW_LEN_DEFAULT = 64;

   // One accelerometer sample.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] accel_x;
      logic signed [SAMPLE_W-1:0] accel_y;
      logic signed [SAMPLE_W-1:0] accel_z;
   } req_payload_type;

   // One window result.
   typedef struct packed {
      logic [OUT_W-1:0] rms_x;
      logic [OUT_W-1:0] rms_y;
      logic [OUT_W-1:0] rms_z;
      logic [OUT_W-1:0] std_x;
      logic [OUT_W-1:0] std_y;
      logic [OUT_W-1:0] std_z;
   } rsp_payload_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_S1MUL,
      ST_RMS_START,
      ST_RMS_WAIT,
      ST_STD_WAIT,
      ST_OUT
   } state_type;

   // Command to the square root unit.
   typedef struct packed {
      logic                  start;
      logic [ROOT_ARG_W-1:0] arg;
   } root_req_type;

   // Status of the square root unit.
   typedef struct packed {
      logic              busy;
      logic              done;
      logic [ROOT_W-1:0] root;
   } root_rsp_type;

endpackage

### hw/rtl/wrsf_if.sv
// Valid/ready channel interfaces for samples and window results.
interface wrsf_req_if import wrsf_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface wrsf_rsp_if import wrsf_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/wrsf_square.sv
// Shared registered squaring unit for samples and window sums.
module wrsf_square #(
   parameter int OPERAND_W = 22
) (
   input  logic                          clock,
   input  logic signed [OPERAND_W-1:0]   operand,
   output logic signed [2*OPERAND_W-1:0] product_ff
);

   logic signed [2*OPERAND_W-1:0] product_in;

   // The square of a signed value is never negative.
   assign product_in = operand * operand;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

### hw/rtl/wrsf_isqrt.sv
// Bit-serial floor square root, one result bit per cycle.
module wrsf_isqrt import wrsf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  root_req_type root_req,
   output root_rsp_type root_rsp
);

   localparam int REM_W = ROOT_W + 3;
   localparam int STEP_W = $clog2(ROOT_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [ROOT_ARG_W-1:0] arg_ff, arg_in;
   logic [REM_W-1:0]      rem_shift;
   logic [REM_W-1:0]      trial;

   // Bring in the next two argument bits and try the next root bit.
   assign rem_shift = {rem_ff[REM_W-3:0], arg_ff[ROOT_ARG_W-1 -: 2]};
   assign trial = REM_W'({root_ff, 2'b01});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      arg_in = arg_ff;
      if (root_req.start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(ROOT_W - 1);
         rem_in = '0;
         root_in = '0;
         arg_in = root_req.arg;
      end else if (busy_ff) begin
         arg_in = {arg_ff[ROOT_ARG_W-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in = rem_shift - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      arg_ff <= arg_in;
   end

   assign root_rsp.busy = busy_ff;
   assign root_rsp.done = done_ff;
   assign root_rsp.root = root_ff;

endmodule

### hw/rtl/window_rms_stddev_features.sv
// Top level: windowed per-axis RMS and standard deviation of accelerometer samples.
//
// Usage: req_chan carries one three-axis sample (signed 16-bit counts) per item.
// rsp_chan carries one item per window of WINDOW_LEN samples (a power of two):
// RMS and population standard deviation of each axis, unsigned with 4 fraction bits.
// For each accepted sample the shared squaring unit squares the three axes one
// after another and the running totals are updated; req_chan is ready again
// after that. On the last sample of a window the sequencer squares each axis
// sum and runs six roots through the bit-serial root unit, 20 steps each.
// The result sits in an output register until taken. If the receiver stalls,
// the block keeps the next result in its working registers and does not take
// a new sample until the output register is free. Reset is synchronous and
// clears the totals, the sample count and the output valid.
module window_rms_stddev_features import wrsf_pkg::*; #(
   parameter int WINDOW_LEN = WINDOW_LEN_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   wrsf_req_if.sink    req_chan,
   wrsf_rsp_if.source  rsp_chan
);

   localparam int LOG2 = $clog2(WINDOW_LEN);
   localparam int SUM_W = SAMPLE_W + LOG2;
   localparam int SQ_W = 2 * SAMPLE_W - 1 + LOG2;
   localparam int PROD_W = 2 * SUM_W;
   localparam int DIFF_W = PROD_W + 1;

   state_type                   state_ff, state_in;
   logic [AXIS_W-1:0]           axis_ff, axis_in;
   logic [LOG2-1:0]             count_ff, count_in;
   logic signed [SAMPLE_W-1:0]  sample_ff [AXES];
   logic signed [SAMPLE_W-1:0]  sample_in [AXES];
   logic signed [SUM_W-1:0]     sum_ff [AXES];
   logic signed [SUM_W-1:0]     sum_in [AXES];
   logic [SQ_W-1:0]             sq_ff [AXES];
   logic [SQ_W-1:0]             sq_in [AXES];
   logic [ROOT_W-1:0]           rms_ff [AXES];
   logic [ROOT_W-1:0]           rms_in [AXES];
   logic [ROOT_W-1:0]           std_ff [AXES];
   logic [ROOT_W-1:0]           std_in [AXES];
   logic [ROOT_ARG_W-1:0]       std_arg_ff, std_arg_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_payload_type             rsp_data_ff, rsp_data_in;

   logic signed [SAMPLE_W-1:0]  sample_sel;
   logic signed [SUM_W-1:0]     sq_operand;
   logic signed [PROD_W-1:0]    product_ff;
   logic [PROD_W-1:0]           ns2_ext;
   logic signed [DIFF_W-1:0]    diff_full;
   logic [PROD_W-1:0]           diff_pos;
   logic [PROD_W+7:0]           std_wide;
   logic [SQ_W+7:0]             rms_wide;
   logic                        last_axis;
   logic                        last_sample;
   logic                        out_free;
   root_req_type                root_req;
   root_rsp_type                root_rsp;

   // Shared squaring unit: samples during accumulation, sums at window end.
   assign sample_sel = sample_ff[axis_ff];
   assign sq_operand = (state_ff == ST_MUL) ? SUM_W'(sample_sel) : sum_ff[axis_ff];

   wrsf_square #(
      .OPERAND_W (SUM_W)
   ) u_square (
      .clock      (clock),
      .operand    (sq_operand),
      .product_ff (product_ff)
   );

   wrsf_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .root_req (root_req),
      .root_rsp (root_rsp)
   );

   // Root arguments: 256*S2/N and 256*(N*S2 - S1*S1)/N^2, both by shifts.
   assign ns2_ext = PROD_W'({sq_ff[axis_ff], {LOG2{1'b0}}});
   assign diff_full = $signed({1'b0, ns2_ext}) - $signed({product_ff[PROD_W-1], product_ff});
   assign diff_pos = diff_full[DIFF_W-1] ? '0 : diff_full[PROD_W-1:0];
   assign std_wide = {diff_pos, 8'b0} >> (2 * LOG2);
   assign rms_wide = {sq_ff[axis_ff], 8'b0} >> LOG2;

   assign last_axis = (axis_ff == AXIS_W'(AXES - 1));
   assign last_sample = (count_ff == LOG2'(WINDOW_LEN - 1));
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // Sequencer: next state and datapath updates.
   always_comb begin
      state_in = state_ff;
      axis_in = axis_ff;
      count_in = count_ff;
      sample_in = sample_ff;
      sum_in = sum_ff;
      sq_in = sq_ff;
      rms_in = rms_ff;
      std_in = std_ff;
      std_arg_in = std_arg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in = rsp_data_ff;
      root_req.start = 1'b0;
      root_req.arg = rms_wide[ROOT_ARG_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               sample_in[0] = req_chan.payload.accel_x;
               sample_in[1] = req_chan.payload.accel_y;
               sample_in[2] = req_chan.payload.accel_z;
               axis_in = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            sum_in[axis_ff] = sum_ff[axis_ff] + SUM_W'(sample_sel);
            sq_in[axis_ff] = sq_ff[axis_ff] + product_ff[SQ_W-1:0];
            if (!last_axis) begin
               axis_in = axis_ff + 1'b1;
               state_in = ST_MUL;
            end else if (last_sample) begin
               axis_in = '0;
               state_in = ST_S1MUL;
            end else begin
               count_in = count_ff + 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_S1MUL: begin
            state_in = ST_RMS_START;
         end
         ST_RMS_START: begin
            root_req.start = 1'b1;
            std_arg_in = std_wide[ROOT_ARG_W-1:0];
            state_in = ST_RMS_WAIT;
         end
         ST_RMS_WAIT: begin
            if (root_rsp.done) begin
               rms_in[axis_ff] = root_rsp.root;
               root_req.start = 1'b1;
               root_req.arg = std_arg_ff;
               state_in = ST_STD_WAIT;
            end
         end
         ST_STD_WAIT: begin
            if (root_rsp.done) begin
               std_in[axis_ff] = root_rsp.root;
               if (last_axis) begin
                  state_in = ST_OUT;
               end else begin
                  axis_in = axis_ff + 1'b1;
                  state_in = ST_S1MUL;
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.rms_x = rms_ff[0];
               rsp_data_in.rms_y = rms_ff[1];
               rsp_data_in.rms_z = rms_ff[2];
               rsp_data_in.std_x = std_ff[0];
               rsp_data_in.std_y = std_ff[1];
               rsp_data_in.std_z = std_ff[2];
               for (int a = 0; a < AXES; a++) begin
                  sum_in[a] = '0;
                  sq_in[a] = '0;
               end
               count_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Totals, count and output valid are cleared at reset; payload is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < AXES; a++) begin
            sum_ff[a] <= '0;
            sq_ff[a] <= '0;
         end
      end else begin
         axis_ff <= axis_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff <= sum_in;
         sq_ff <= sq_in;
      end
      sample_ff <= sample_in;
      rms_ff <= rms_in;
      std_ff <= std_in;
      std_arg_ff <= std_arg_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   // An accepted item always starts the squaring sequence.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == ST_MUL && axis_ff == '0))
      else $error("accepted item did not start the squaring sequence");

   // The root unit is never restarted while it is still iterating.
   a_root_no_overlap: assert property (@(posedge clock) disable iff (reset)
      root_req.start |-> !root_rsp.busy)
      else $error("root unit started while busy");

   // A finished root is only seen while the sequencer waits for it.
   a_root_done_waited: assert property (@(posedge clock) disable iff (reset)
      root_rsp.done |-> (state_ff == ST_RMS_WAIT || state_ff == ST_STD_WAIT))
      else $error("root finished outside a wait state");

   // Loading a result clears the window and returns to idle.
   a_result_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_free) |=>
         (rsp_valid_ff && count_ff == '0 && state_ff == ST_IDLE))
      else $error("result load did not clear the window");
`endif

endmodule

### bench/window_rms_stddev_features_tb.sv
// Self-checking testbench for the windowed RMS and standard deviation block.
`timescale 1ns / 1ps

module window_rms_stddev_features_tb;
   import wrsf_pkg::*;

   localparam int WIN = 64;
   localparam int DIRECTED_ITEMS = 24;
   localparam int TOTAL_ITEMS = 27 * WIN;
   localparam int SETTLE_CYCLES = 300;
   localparam int MAX_GAP = 16;

   // Kinds of window content used by the random part.
   typedef enum int {
      WIN_RANDOM,
      WIN_CONSTANT,
      WIN_EXTREMES,
      WIN_ALL_MIN,
      WIN_ALL_MAX,
      WIN_SMALL,
      WIN_KIND_COUNT
   } window_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wrsf_req_if req_if ();
   wrsf_rsp_if rsp_if ();

   window_rms_stddev_features #(.WINDOW_LEN(WIN)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   req_payload_type pending_samples[$];
   rsp_payload_type expected_windows[$];
   int mismatch_count = 0;

   // Running window totals of the predictor.
   longint          win_sum[AXES];
   longint unsigned win_square_sum[AXES];
   int              win_count = 0;

   int send_wait = 0;
   int take_wait = 0;
   bit send_burst = 1'b0;
   bit take_burst = 1'b0;

   initial begin
      for (int a = 0; a < AXES; a++) begin
         win_sum[a] = 0;
         win_square_sum[a] = 0;
      end
   end

   // Floor square root, one result bit at a time from the top.
   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned root;
      longint unsigned cand;
      root = 0;
      for (int b = 27; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (cand * cand <= v) begin
            root = cand;
         end
      end
      return root;
   endfunction

   function automatic int draw_gap(input bit burst);
      return burst ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // Adds one sample to the window totals; on the last sample of a window the
   // expected result is queued and the totals start over.
   task automatic accumulate_sample(input req_payload_type smp);
      logic signed [SAMPLE_W-1:0] axis_val[AXES];
      longint          s;
      longint unsigned mag;
      longint unsigned diff;
      longint unsigned spread;
      logic [OUT_W-1:0] rms[AXES];
      logic [OUT_W-1:0] sd[AXES];
      rsp_payload_type  res;
      axis_val[0] = smp.accel_x;
      axis_val[1] = smp.accel_y;
      axis_val[2] = smp.accel_z;
      for (int a = 0; a < AXES; a++) begin
         s = axis_val[a];
         win_sum[a] += s;
         win_square_sum[a] += longint'(s * s);
      end
      win_count++;
      if (win_count == WIN) begin
         for (int a = 0; a < AXES; a++) begin
            mag = (win_sum[a] < 0) ? -win_sum[a] : win_sum[a];
            spread = WIN * win_square_sum[a];
            diff = (spread >= mag * mag) ? spread - mag * mag : 0;
            rms[a] = OUT_W'(floor_root((win_square_sum[a] << 8) / WIN));
            sd[a] = OUT_W'(floor_root((diff << 8) / (WIN * WIN)));
            win_sum[a] = 0;
            win_square_sum[a] = 0;
         end
         res.rms_x = rms[0];
         res.rms_y = rms[1];
         res.rms_z = rms[2];
         res.std_x = sd[0];
         res.std_y = sd[1];
         res.std_z = sd[2];
         expected_windows.push_back(res);
         win_count = 0;
      end
   endtask

   task automatic compare_field(input string name, input logic [OUT_W-1:0] want,
                                input logic [OUT_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // One axis value for the given kind of window.
   function automatic logic [SAMPLE_W-1:0] axis_value(input window_kind_type kind,
                                                      input logic [SAMPLE_W-1:0] level);
      logic [3:0] nib;
      nib = 4'($urandom);
      case (kind)
         WIN_CONSTANT: return level;
         WIN_EXTREMES: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         WIN_ALL_MIN:  return 16'h8000;
         WIN_ALL_MAX:  return 16'h7FFF;
         WIN_SMALL:    return {{12{nib[3]}}, nib};
         default:      return 16'($urandom);
      endcase
   endfunction

   // Sample driver: holds each item until taken, then idles for a drawn gap.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_wait <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            accumulate_sample(req_if.payload);
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_wait != 0) begin
               send_wait <= send_wait - 1;
               req_if.valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               req_if.payload <= pending_samples.pop_front();
               req_if.valid <= 1'b1;
               send_wait <= draw_gap(send_burst);
               send_burst <= ($urandom_range(0, 39) == 0) ? ~send_burst : send_burst;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: stalls for a drawn number of cycles once a result shows up.
   always @(posedge clock) begin : result_monitor
      rsp_payload_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         take_wait <= 0;
      end else if (rsp_if.valid && rsp_if.ready) begin
         if (expected_windows.size() == 0) begin
            $error("result item with no window expected");
            mismatch_count++;
         end else begin
            want = expected_windows.pop_front();
            compare_field("rms_x", want.rms_x, rsp_if.payload.rms_x);
            compare_field("rms_y", want.rms_y, rsp_if.payload.rms_y);
            compare_field("rms_z", want.rms_z, rsp_if.payload.rms_z);
            compare_field("std_x", want.std_x, rsp_if.payload.std_x);
            compare_field("std_y", want.std_y, rsp_if.payload.std_y);
            compare_field("std_z", want.std_z, rsp_if.payload.std_z);
         end
         take_wait <= draw_gap(take_burst);
         rsp_if.ready <= 1'b0;
         take_burst <= ($urandom_range(0, 3) == 0) ? ~take_burst : take_burst;
      end else if (take_wait != 0) begin
         if (rsp_if.valid) begin
            take_wait <= take_wait - 1;
         end
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      logic [SAMPLE_W-1:0] corners[8];
      logic [SAMPLE_W-1:0] level;
      window_kind_type kind;
      req_payload_type smp;
      int w;

      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;

      corners = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                  16'h0001, 16'h5555, 16'hAAAA, 16'h00FF};

      // Directed extremes at the start of the first window.
      for (int i = 0; i < DIRECTED_ITEMS; i++) begin
         smp.accel_x = corners[i % 8];
         smp.accel_y = corners[(i + 3) % 8];
         smp.accel_z = corners[(i + 5) % 8];
         pending_samples.push_back(smp);
      end

      // Random windows; the first few kinds are taken in turn so that each
      // special window shape appears, the rest are drawn.
      kind = WIN_RANDOM;
      level = '0;
      for (int n = DIRECTED_ITEMS; n < TOTAL_ITEMS; n++) begin
         if (n % WIN == 0) begin
            w = n / WIN;
            if (w <= int'(WIN_KIND_COUNT) - 1) begin
               kind = window_kind_type'(w);
            end else begin
               kind = window_kind_type'($urandom_range(0, int'(WIN_KIND_COUNT) - 1));
            end
            level = 16'($urandom);
         end
         smp.accel_x = axis_value(kind, level);
         smp.accel_y = axis_value(kind, level);
         smp.accel_z = axis_value(kind, level);
         pending_samples.push_back(smp);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_samples.size() != 0 || req_if.valid) begin
         @(posedge clock);
      end
      while (expected_windows.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
